@@ design/ptbs_pkg.sv @@
// Shared types, constants and codes for the priority token bucket shaper.
package ptbs_pkg;

    // Session table geometry
    localparam int NUM_SESSIONS = 64;
    localparam int IDX_W        = $clog2(NUM_SESSIONS);

    // Field widths
    localparam int SLOT_W   = 6;
    localparam int LEN_W    = 16;
    localparam int CLASS_W  = 3;
    localparam int TIME_W   = 64;
    localparam int LEVEL_W  = 20;
    localparam int RATE_W   = 16;
    localparam int COUNT_W  = 32;
    localparam int PATH_W   = 2;
    localparam int COST_W   = LEN_W + 1;
    localparam int SHIFT    = 30;
    // Elapsed quanta above this many bits overflow the bucket unless the refill rate is zero
    localparam int QUANTA_W = LEVEL_W;
    localparam int PROD_W   = QUANTA_W + RATE_W;

    // Stream payload widths (packed, padded to bytes)
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 112;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    // Register reset values
    localparam logic [LEVEL_W-1:0] BUCKET_SIZE_RST = LEVEL_W'(1000);
    localparam logic [RATE_W-1:0]  REFILL_RATE_RST = RATE_W'(100);
    localparam logic [LEVEL_W-1:0] BURST_SIZE_RST  = LEVEL_W'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUCKET_SIZE = 8'd0,
        REG_REFILL_RATE = 8'd1,
        REG_BURST_SIZE  = 8'd2
    } cfg_reg_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_CRITICAL = 3'd0,
        CLS_CONTROL  = 3'd1,
        CLS_URGENT   = 3'd2,
        CLS_NORMAL   = 3'd3,
        CLS_BULK     = 3'd4
    } prio_class_t;

    typedef enum logic [PATH_W-1:0] {
        PATH_NEW     = 2'd0,
        PATH_BUCKET  = 2'd1,
        PATH_BURST   = 2'd2,
        PATH_DROPPED = 2'd3
    } path_t;

    // Per-session record held in the session table
    typedef struct packed {
        logic [TIME_W-1:0]  last_time;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] burst;
        logic [COUNT_W-1:0] bytes;
        logic [COUNT_W-1:0] packets;
    } session_t;

    localparam int SESSION_W = $bits(session_t);

    // Shaper configuration
    typedef struct packed {
        logic [LEVEL_W-1:0] bucket_size;
        logic [RATE_W-1:0]  refill_rate;
        logic [LEVEL_W-1:0] burst_size;
    } shaper_cfg_t;

    // One packet as seen by the update logic
    typedef struct packed {
        logic [LEN_W-1:0]   length;
        logic [CLASS_W-1:0] pclass;
        logic [TIME_W-1:0]  timestamp;
    } packet_t;

    // Verdict for one packet
    typedef struct packed {
        logic  drop;
        path_t path;
    } verdict_t;

endpackage

@@ design/priority_token_bucket_shaper.sv @@
// Top level of the priority token bucket shaper.
//
// Packets enter on the s_ stream channel, one transaction per packet; each
// produces exactly one verdict transaction on the m_ channel, in order.
// The cfg channel writes the bucket size, refill rate and burst size; it is
// always ready and is meant to be used only while no packet is in flight.
// The edge that takes a packet also reads its session record from the
// table; the edge that moves it on from the compute stage computes refill,
// charge and counters and loads the verdict register while writing the
// record back. One packet can be taken every cycle unless back-pressure
// holds the compute stage; a packet that follows one on the same session
// picks up the new record from a bypass register instead of the table.
// The record table holds 64 sessions; a valid flag per session, cleared at
// reset, marks opened sessions, so no clearing pass is needed. Reset
// (aresetn low, synchronous) empties the pipeline and restores the default
// register values. When m_tready is low the verdict holds, the compute
// stage holds its packet, and s_tready drops once both are full.
module priority_token_bucket_shaper
    import ptbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // session_slot[5:0], packet_length[21:6], priority_class[24:22],
    // timestamp[88:25], zero pad
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // drop[0], path[2:1], tokens_left[22:3], burst_left[42:23],
    // bytes_total[74:43], packets_total[106:75], zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    shaper_cfg_t            cfg_reg;
    logic [NUM_SESSIONS-1:0] open_reg;
    logic                   stg_valid_reg;
    logic [IDX_W-1:0]       stg_idx_reg;
    packet_t                stg_pkt_reg;
    logic                   byp_valid_reg;
    session_t               byp_rec_reg;
    logic                   out_valid_reg;
    verdict_t               out_verdict_reg;
    session_t               out_rec_reg;

    logic                   s_accept;
    logic                   advance;
    logic [IDX_W-1:0]       s_idx;
    packet_t                s_pkt;
    session_t               mem_rd;
    session_t               cur_rec;
    session_t               nxt_rec;
    verdict_t               verdict;

    // Unpack input
    assign s_idx           = s_tdata[IDX_W-1:0];
    assign s_pkt.length    = s_tdata[SLOT_W +: LEN_W];
    assign s_pkt.pclass    = s_tdata[SLOT_W+LEN_W +: CLASS_W];
    assign s_pkt.timestamp = s_tdata[SLOT_W+LEN_W+CLASS_W +: TIME_W];

    // Handshake
    assign advance   = stg_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !stg_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bucket_size <= BUCKET_SIZE_RST;
            cfg_reg.refill_rate <= REFILL_RATE_RST;
            cfg_reg.burst_size  <= BURST_SIZE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BUCKET_SIZE: cfg_reg.bucket_size <= cfg_data[LEVEL_W-1:0];
                REG_REFILL_RATE: cfg_reg.refill_rate <= cfg_data[RATE_W-1:0];
                REG_BURST_SIZE:  cfg_reg.burst_size  <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Session table
    ptbs_state_mem u_mem (
        .aclk    (aclk),
        .wr_en   (advance),
        .wr_addr (stg_idx_reg),
        .wr_data (nxt_rec),
        .rd_en   (s_accept),
        .rd_addr (s_idx),
        .rd_data (mem_rd)
    );

    // Compute stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else if (s_accept) begin
            stg_valid_reg <= 1'b1;
            byp_valid_reg <= advance && (stg_idx_reg == s_idx);
        end else if (advance) begin
            stg_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
    end

    // Compute stage payload and write-back bypass
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stg_idx_reg <= s_idx;
            stg_pkt_reg <= s_pkt;
            byp_rec_reg <= nxt_rec;
        end
    end

    // Session valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else if (advance) begin
            open_reg[stg_idx_reg] <= 1'b1;
        end
    end

    assign cur_rec = byp_valid_reg ? byp_rec_reg : mem_rd;

    ptbs_update u_update (
        .open    (open_reg[stg_idx_reg]),
        .cur     (cur_rec),
        .pkt     (stg_pkt_reg),
        .cfg     (cfg_reg),
        .nxt     (nxt_rec),
        .verdict (verdict)
    );

    // Verdict register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_verdict_reg <= verdict;
            out_rec_reg     <= nxt_rec;
        end
    end

    // Pack output
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_rec_reg.packets,
                       out_rec_reg.bytes,
                       out_rec_reg.burst,
                       out_rec_reg.level,
                       out_verdict_reg.path,
                       out_verdict_reg.drop};

endmodule

@@ design/ptbs_state_mem.sv @@
// Session table: one write port, one read port with registered read data.
module ptbs_state_mem
    import ptbs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  session_t             wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output session_t             rd_data
);

    session_t mem [NUM_SESSIONS];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/ptbs_update.sv @@
// Per-packet bucket refill, cost charge and counter update.
module ptbs_update
    import ptbs_pkg::*;
(
    input  logic        open,       // session already open
    input  session_t    cur,
    input  packet_t     pkt,
    input  shaper_cfg_t cfg,
    output session_t    nxt,
    output verdict_t    verdict
);

    logic [TIME_W-1:0]   diff;
    logic                moved;
    logic                diff_hi;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W:0]     sum;
    logic                sat;
    logic [LEVEL_W-1:0]  refilled;
    logic [COST_W-1:0]   cost;
    logic [LEVEL_W-1:0]  cost_ext;
    logic                pay_bucket;
    logic                pay_burst;
    logic                may_burst;

    // Refill by elapsed 2^30 ns quanta times the rate, saturated at bucket size
    assign diff    = pkt.timestamp - cur.last_time;
    assign moved   = (pkt.timestamp != cur.last_time);
    assign diff_hi = |diff[TIME_W-1:SHIFT+QUANTA_W];
    assign prod    = PROD_W'(diff[SHIFT+QUANTA_W-1:SHIFT]) * PROD_W'(cfg.refill_rate);
    assign sum     = (PROD_W+1)'(cur.level) + (PROD_W+1)'(prod);
    assign sat     = (diff_hi && (cfg.refill_rate != '0))
                     || (sum > (PROD_W+1)'(cfg.bucket_size));
    assign refilled = !moved ? cur.level :
                      sat    ? cfg.bucket_size : sum[LEVEL_W-1:0];

    // Cost weighted by class; unknown classes cost the length
    always_comb begin
        case (pkt.pclass)
            CLS_CRITICAL: cost = COST_W'(pkt.length >> 1);
            CLS_BULK:     cost = {pkt.length, 1'b0};
            default:      cost = COST_W'(pkt.length);
        endcase
    end

    assign cost_ext   = LEVEL_W'(cost);
    assign may_burst  = (pkt.pclass == CLS_CRITICAL) || (pkt.pclass == CLS_CONTROL);
    assign pay_bucket = (refilled >= cost_ext);
    assign pay_burst  = may_burst && (cur.burst >= cost_ext);

    // Next session record and verdict
    always_comb begin
        nxt           = cur;
        verdict.drop  = 1'b0;
        verdict.path  = PATH_NEW;
        if (!open) begin
            nxt.last_time = pkt.timestamp;
            nxt.level     = cfg.bucket_size;
            nxt.burst     = cfg.burst_size;
            nxt.bytes     = COUNT_W'(pkt.length);
            nxt.packets   = COUNT_W'(1);
        end else begin
            nxt.last_time = pkt.timestamp;
            nxt.level     = refilled;
            if (pay_bucket) begin
                nxt.level     = refilled - cost_ext;
                nxt.bytes     = cur.bytes + COUNT_W'(pkt.length);
                nxt.packets   = cur.packets + COUNT_W'(1);
                verdict.path  = PATH_BUCKET;
            end else if (pay_burst) begin
                nxt.burst     = cur.burst - cost_ext;
                nxt.bytes     = cur.bytes + COUNT_W'(pkt.length);
                nxt.packets   = cur.packets + COUNT_W'(1);
                verdict.path  = PATH_BURST;
            end else begin
                verdict.drop  = 1'b1;
                verdict.path  = PATH_DROPPED;
            end
        end
    end

endmodule

@@ bench/ptbs_verdict_checker.sv @@
// Verdict checker: predicts each packet's verdict and compares it with the output stream.
module ptbs_verdict_checker
    import ptbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    output int                    mismatches,
    output int                    verdicts_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // Verdict layout as carried on m_tdata, drop in bit 0
    typedef struct packed {
        logic [COUNT_W-1:0] packets;
        logic [COUNT_W-1:0] bytes;
        logic [LEVEL_W-1:0] burst;
        logic [LEVEL_W-1:0] tokens;
        path_t              path;
        logic               drop;
    } verdict_rec_t;

    shaper_cfg_t  shaper_cfg;
    logic         opened   [NUM_SESSIONS];
    session_t     sessions [NUM_SESSIONS];
    verdict_rec_t verdict_q[$];

    // Charge one packet against its session and return the verdict it earns
    function automatic verdict_rec_t charge_packet(input logic [S_DATA_W-1:0] d);
        int unsigned        idx;
        logic [LEN_W-1:0]   len;
        logic [CLASS_W-1:0] cls;
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  refilled;
        logic [COST_W-1:0]  cost;
        session_t           rec;
        verdict_rec_t       v;
        idx = int'(d[SLOT_W-1:0]) % NUM_SESSIONS;
        len = d[SLOT_W +: LEN_W];
        cls = d[SLOT_W+LEN_W +: CLASS_W];
        now = d[SLOT_W+LEN_W+CLASS_W +: TIME_W];
        v.drop = 1'b0;
        if (!opened[idx]) begin
            // first packet opens the session and passes free
            opened[idx]   = 1'b1;
            rec.last_time = now;
            rec.level     = shaper_cfg.bucket_size;
            rec.burst     = shaper_cfg.burst_size;
            rec.bytes     = COUNT_W'(len);
            rec.packets   = COUNT_W'(1);
            v.path        = PATH_NEW;
        end else begin
            rec = sessions[idx];
            // refill only when time moved; elapsed wraps mod 2^64, sum saturates
            if (now != rec.last_time) begin
                refilled = ((now - rec.last_time) >> SHIFT) * TIME_W'(shaper_cfg.refill_rate)
                           + TIME_W'(rec.level);
                if (refilled > TIME_W'(shaper_cfg.bucket_size))
                    rec.level = shaper_cfg.bucket_size;
                else
                    rec.level = LEVEL_W'(refilled);
                rec.last_time = now;
            end
            // critical pays half, bulk pays double, unknown classes pay as normal
            case (cls)
                CLS_CRITICAL: cost = COST_W'(len >> 1);
                CLS_BULK:     cost = {len, 1'b0};
                default:      cost = COST_W'(len);
            endcase
            if (rec.level >= cost) begin
                rec.level = rec.level - LEVEL_W'(cost);
                v.path    = PATH_BUCKET;
            end else if ((cls == CLS_CRITICAL || cls == CLS_CONTROL) && rec.burst >= cost) begin
                rec.burst = rec.burst - LEVEL_W'(cost);
                v.path    = PATH_BURST;
            end else begin
                v.drop = 1'b1;
                v.path = PATH_DROPPED;
            end
            if (!v.drop) begin
                rec.bytes   = rec.bytes + COUNT_W'(len);
                rec.packets = rec.packets + COUNT_W'(1);
            end
        end
        sessions[idx] = rec;
        v.tokens  = rec.level;
        v.burst   = rec.burst;
        v.bytes   = rec.bytes;
        v.packets = rec.packets;
        return v;
    endfunction

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Track register writes, predict on input transactions, compare on output ones
    always @(posedge aclk) begin
        verdict_rec_t want;
        verdict_rec_t got;
        if (!aresetn) begin
            shaper_cfg.bucket_size = BUCKET_SIZE_RST;
            shaper_cfg.refill_rate = REFILL_RATE_RST;
            shaper_cfg.burst_size  = BURST_SIZE_RST;
            for (int i = 0; i < NUM_SESSIONS; i++)
                opened[i] = 1'b0;
            verdict_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BUCKET_SIZE: shaper_cfg.bucket_size = cfg_data[LEVEL_W-1:0];
                    REG_REFILL_RATE: shaper_cfg.refill_rate = cfg_data[RATE_W-1:0];
                    REG_BURST_SIZE:  shaper_cfg.burst_size  = cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(verdict_rec_t)-1:0];
                if (verdict_q.size() == 0) begin
                    $error("verdict transaction with no packet outstanding");
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("drop",          want.drop,    got.drop);
                    check_field("path",          want.path,    got.path);
                    check_field("tokens_left",   want.tokens,  got.tokens);
                    check_field("burst_left",    want.burst,   got.burst);
                    check_field("bytes_total",   want.bytes,   got.bytes);
                    check_field("packets_total", want.packets, got.packets);
                end
            end
            if (s_tvalid && s_tready)
                verdict_q.push_back(charge_packet(s_tdata));
        end
        verdicts_due <= verdict_q.size();
    end

endmodule

@@ bench/tb_priority_token_bucket_shaper.sv @@
// Testbench top: drives packets and register writes into the shaper and reports the verdict.
module tb_priority_token_bucket_shaper
    import ptbs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 70;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_AT       = 110;
    localparam int HOLD_CYCLES   = 250;
    localparam int QUIET_LIMIT   = 2000;

    // Class codes outside the named set, treated as normal
    localparam logic [CLASS_W-1:0]   CLS_ODD_LOW   = 3'd5;
    localparam logic [CLASS_W-1:0]   CLS_ODD_HIGH  = 3'd7;
    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LOW  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HIGH = 8'hFF;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  cfg_valid;
    logic                  cfg_ready;

    int                    failures;
    int                    verdicts_due;
    bit                    calm = 1'b0;
    logic [TIME_W-1:0]     last_stamp [NUM_SESSIONS];

    always #10 aclk = ~aclk;

    priority_token_bucket_shaper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    ptbs_verdict_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .mismatches   (failures),
        .verdicts_due (verdicts_due)
    );

    // Offer one packet, with an occasional gap before it
    task automatic offer(input logic [SLOT_W-1:0] slot, input logic [LEN_W-1:0] len,
                         input logic [CLASS_W-1:0] cls, input logic [TIME_W-1:0] ts);
        if (!calm && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tdata  <= S_DATA_W'({ts, cls, len, slot});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        last_stamp[slot] = ts;
    endtask

    // Next timestamp for a slot: same time, small step, whole quanta, random or backward
    function automatic logic [TIME_W-1:0] next_stamp(input int slot);
        logic [TIME_W-1:0] prev;
        int                pick;
        prev = last_stamp[slot];
        pick = $urandom_range(99);
        if (pick < 25)
            return prev;
        if (pick < 45)
            return prev + TIME_W'($urandom);
        if (pick < 80)
            return prev + (TIME_W'($urandom_range(20)) << SHIFT) + TIME_W'($urandom_range(1000));
        if (pick < 90)
            return {$urandom, $urandom};
        return prev - TIME_W'($urandom_range(5000, 1));
    endfunction

    // Mostly short packets, some long ones, any class
    task automatic random_packet(input int slot_hi);
        int               slot;
        int               pick;
        logic [LEN_W-1:0] len;
        slot = $urandom_range(slot_hi);
        pick = $urandom_range(99);
        if (pick < 70)
            len = LEN_W'($urandom_range(600));
        else if (pick < 90)
            len = LEN_W'($urandom_range(4000));
        else
            len = LEN_W'($urandom);
        offer(SLOT_W'(slot), len, CLASS_W'($urandom_range(7)), next_stamp(slot));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Rate write carries junk in the unused upper data bits
    task automatic configure(input logic [LEVEL_W-1:0] bsize, input logic [RATE_W-1:0] rate,
                             input logic [LEVEL_W-1:0] burst);
        write_reg(REG_BUCKET_SIZE, bsize);
        write_reg(REG_REFILL_RATE, {(CFG_DATA_W-RATE_W)'($urandom), rate});
        write_reg(REG_BURST_SIZE, burst);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every outstanding verdict, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Output side: random back-pressure, one long hold-off, none in the calm phase
    initial begin
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                taken++;
            if (!held && taken >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    // Watchdog: too long without any transaction ends the run
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Stimulus
    initial begin
        int slot_hi;
        for (int i = 0; i < NUM_SESSIONS; i++)
            last_stamp[i] = '0;
        aresetn   <= 1'b0;
        s_tdata   <= '0;
        s_tvalid  <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cfg_valid <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // writes to unused indexes must leave the defaults alone
        write_reg(REG_NONE_LOW, '1);
        write_reg(REG_NONE_HIGH, '0);
        cfg_valid <= 1'b0;

        // directed packets at default settings
        offer(6'd0, 16'd100, CLS_NORMAL, 64'd0);            // opens slot
        offer(6'd0, 16'd100, CLS_NORMAL, 64'd0);            // same time, bucket pays
        offer(6'd0, 16'hFFFF, CLS_CRITICAL, 64'd0);         // too big even halved
        offer(6'd0, 16'd300, CLS_CRITICAL, 64'd0);          // half cost from bucket
        offer(6'd1, 16'hFFFF, CLS_BULK, '1);                // opens at max time
        offer(6'd1, 16'd500, CLS_BULK, '1);                 // double cost empties bucket
        offer(6'd1, 16'd150, CLS_CONTROL, '1);              // control falls to burst
        offer(6'd1, 16'd1, CLS_URGENT, '1);                 // urgent may not use burst
        offer(6'd1, 16'd0, CLS_ODD_HIGH, '1);               // zero cost passes empty bucket
        offer(6'd1, 16'd10, CLS_ODD_LOW, '1);               // unknown class, no burst
        offer(6'd1, 16'd100, CLS_CRITICAL, '1);             // burst drained exactly
        offer(6'd1, 16'd2, CLS_CONTROL, '1);                // both empty
        offer(6'd1, 16'd0, CLS_BULK, 64'd0);                // time wraps by one ns
        offer(6'd1, 16'd500, CLS_NORMAL, (64'd5 << SHIFT) + 64'd7);
        offer(6'd1, 16'd1000, CLS_NORMAL, 64'h8000_0000_0000_0000); // refill saturates
        offer(6'd63, 16'hFFFF, CLS_BULK, 64'h5555_5555_5555_5555);
        offer(6'd63, 16'hFFFF, CLS_BULK, 64'h5555_5555_5555_5555);
        offer(6'd63, 16'hFFFF, CLS_ODD_HIGH, 64'h5555_5555_5555_5555 + (64'd1 << 40));
        offer(6'd42, 16'hAAAA, CLS_CONTROL, 64'hAAAA_AAAA_AAAA_AAAA);
        offer(6'd21, 16'h5555, CLS_CRITICAL, 64'h0123_4567_89AB_CDEF);

        // random phases, each under its own settings; the slot range widens per phase
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1: configure('1, '1, '1);
                    2: configure('0, '0, '0);
                    3: configure(LEVEL_W'(500), RATE_W'(1), LEVEL_W'(50));
                    4: configure(LEVEL_W'($urandom_range(5000)), RATE_W'($urandom_range(2000)),
                                 LEVEL_W'($urandom_range(3000)));
                    5: configure(LEVEL_W'($urandom), RATE_W'($urandom), LEVEL_W'($urandom));
                    default: configure(LEVEL_W'(2000), RATE_W'(300), LEVEL_W'(400));
                endcase
            end
            calm    = (p == 4);
            slot_hi = (15 + 8 * p > NUM_SESSIONS - 1) ? NUM_SESSIONS - 1 : 15 + 8 * p;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_packet(slot_hi);
        end

        drain();
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
